FILE: src/fsa_pkg.sv
// Shared types and constants of the fan and strip primitive assembler.
package fsa_pkg;

  // Width of every index field on the ports.
  localparam int FIELD_BITS = 24;

  // Index channels of one vertex: position, normal, color, four UV sets.
  localparam int NUM_CHANNELS = 7;
  localparam int CH_POSITION = 0;
  localparam int CH_NORMAL = 1;
  localparam int CH_COLOR = 2;
  localparam int CH_UV_FIRST = 3;
  localparam int NUM_UV_PORTS = 4;

  // Configuration port.
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 3;
  localparam int UV_COUNT_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ASSEMBLY_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NORMALS_ENABLED = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLORS_ENABLED = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UV_SETS_USED = 2'd3;

  localparam logic MODE_FAN = 1'b0;
  localparam logic MODE_STRIP = 1'b1;

  // Corners of one triangle, and the last one of them.
  localparam int CORNERS = 3;
  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef field_t [NUM_CHANNELS-1:0] corner_t;

  typedef struct packed {
    logic                     assembly_mode;
    logic                     normals_enabled;
    logic                     colors_enabled;
    logic [UV_COUNT_BITS-1:0] uv_sets_used;
  } cfg_t;

endpackage

FILE: src/fan_and_strip_primitive_assembler.sv
// Primitive assembler that turns fan or strip vertices into a triangle list.
//
//   channel | ports                          | one beat carries
//   --------+--------------------------------+-------------------------------
//   input   | in_valid / in_ready / in_*     | one vertex and its start flag
//   result  | out_valid / out_ready / out_*  | one triangle corner
//   config  | cfg_write_en / cfg_index / ... | one register write
//
// A vertex that closes a triangle loads its three corners into the triangle
// register; they leave one per beat, in order, as the result channel takes them.
// The next vertex is taken in the cycle the third corner goes out, so a steady
// stream is paced by the result channel. Reset is synchronous and clears the
// control state; a stalled result channel holds the current corner and stalls
// the input once the triangle register is full.
module fan_and_strip_primitive_assembler #(
  parameter int MAX_UV_SETS = 4,
  parameter int INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Vertex input.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_starts_primitive,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_position_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_normal_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_color_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_a,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_b,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_c,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_d,
  // Corner output.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_position,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_normal,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_color,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_a,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_b,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_c,
  output logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_d,
  output logic                                  out_triangle_done,
  // Configuration writes.
  input  logic                                  cfg_write_en,
  input  logic [fsa_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fsa_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  import fsa_pkg::*;

  // Indices are kept in INDEX_BITS bits, at most the 24 that the ports carry.
  localparam int KEEP_BITS = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
  localparam logic [UV_COUNT_BITS-1:0] MAX_UV = UV_COUNT_BITS'(MAX_UV_SETS);

  typedef logic [NUM_CHANNELS-1:0][KEEP_BITS-1:0] vertex_t;

  cfg_t    cfg_r;
  logic [1:0] seen_r, seen_nxt;
  logic    odd_r, odd_nxt;
  vertex_t anchor_r, anchor_nxt;
  vertex_t prev_r, prev_nxt;

  // Triangle register: three masked corners and the corner being shown.
  corner_t    tri_r [CORNERS];
  logic       busy_r, busy_nxt;
  logic [1:0] slot_r, slot_nxt;

  vertex_t    cur;
  logic       in_fire, out_fire, emit;
  logic [1:0] seen_eff;
  logic       odd_eff;
  logic [UV_COUNT_BITS-1:0] uvs_eff;
  logic [NUM_CHANNELS-1:0]  chan_en;
  vertex_t    c0, c1, c2;
  corner_t    show;

  // Config registers. Writes come only while the block is idle; the user keeps this, not the block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ASSEMBLY_MODE:   cfg_r.assembly_mode   <= cfg_data[0];
        CFG_NORMALS_ENABLED: cfg_r.normals_enabled <= cfg_data[0];
        CFG_COLORS_ENABLED:  cfg_r.colors_enabled  <= cfg_data[0];
        CFG_UV_SETS_USED:    cfg_r.uv_sets_used    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cur[CH_POSITION]   = in_position_index[KEEP_BITS-1:0];
  assign cur[CH_NORMAL]     = in_normal_index[KEEP_BITS-1:0];
  assign cur[CH_COLOR]      = in_color_index[KEEP_BITS-1:0];
  assign cur[CH_UV_FIRST]   = in_uv_index_a[KEEP_BITS-1:0];
  assign cur[CH_UV_FIRST+1] = in_uv_index_b[KEEP_BITS-1:0];
  assign cur[CH_UV_FIRST+2] = in_uv_index_c[KEEP_BITS-1:0];
  assign cur[CH_UV_FIRST+3] = in_uv_index_d[KEEP_BITS-1:0];

  // The input is free when no corner is pending, or the last one leaves now.
  assign out_fire = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && (slot_r == LAST_CORNER));
  assign in_fire  = in_valid && in_ready;

  // A start flag restarts counting before this vertex is placed.
  assign seen_eff = in_starts_primitive ? 2'd0 : seen_r;
  assign odd_eff  = in_starts_primitive ? 1'b0 : odd_r;
  assign emit     = in_fire && (seen_eff == 2'd2);

  // Channel enables. The configuration is steady while a triangle is out (kept by
  // the user, not enforced here), so masking as the triangle is loaded matches masking as it is sent.
  assign uvs_eff = (cfg_r.uv_sets_used > MAX_UV) ? MAX_UV : cfg_r.uv_sets_used;

  always_comb begin
    chan_en = '0;
    chan_en[CH_POSITION] = 1'b1;
    chan_en[CH_NORMAL]   = cfg_r.normals_enabled;
    chan_en[CH_COLOR]    = cfg_r.colors_enabled;
    for (int u = 0; u < NUM_UV_PORTS; u++) begin
      chan_en[CH_UV_FIRST+u] = (UV_COUNT_BITS'(u) < uvs_eff);
    end
  end

  // Corner order: odd strip triangles swap the last two corners to keep
  // the winding.
  always_comb begin
    c0 = anchor_r;
    if ((cfg_r.assembly_mode == MODE_STRIP) && odd_eff) begin
      c1 = cur;
      c2 = prev_r;
    end else begin
      c1 = prev_r;
      c2 = cur;
    end
  end

  // Vertex history.
  always_comb begin
    seen_nxt   = seen_r;
    odd_nxt    = odd_r;
    anchor_nxt = anchor_r;
    prev_nxt   = prev_r;
    if (in_fire) begin
      odd_nxt = odd_eff;
      case (seen_eff)
        2'd0: begin
          anchor_nxt = cur;
          seen_nxt   = 2'd1;
        end
        2'd1: begin
          prev_nxt = cur;
          seen_nxt = 2'd2;
        end
        default: begin
          seen_nxt = 2'd2;
          prev_nxt = cur;
          if (cfg_r.assembly_mode == MODE_STRIP) begin
            anchor_nxt = prev_r;
            odd_nxt    = !odd_eff;
          end
        end
      endcase
    end
  end

  // Corner sequencing.
  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (out_fire) begin
      if (slot_r == LAST_CORNER) begin
        busy_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
    if (emit) begin
      busy_nxt = 1'b1;
      slot_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      odd_r  <= 1'b0;
      busy_r <= 1'b0;
      slot_r <= 2'd0;
    end else begin
      seen_r <= seen_nxt;
      odd_r  <= odd_nxt;
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Vertex stores and the triangle register hold payload only.
  always_ff @(posedge clk) begin
    anchor_r <= anchor_nxt;
    prev_r   <= prev_nxt;
    if (emit) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        tri_r[0][ch] <= chan_en[ch] ? FIELD_BITS'(c0[ch]) : '0;
        tri_r[1][ch] <= chan_en[ch] ? FIELD_BITS'(c1[ch]) : '0;
        tri_r[2][ch] <= chan_en[ch] ? FIELD_BITS'(c2[ch]) : '0;
      end
    end
  end

  always_comb begin
    case (slot_r)
      2'd0:    show = tri_r[0];
      2'd1:    show = tri_r[1];
      default: show = tri_r[2];
    endcase
  end

  assign out_valid         = busy_r;
  assign out_position      = show[CH_POSITION];
  assign out_normal        = show[CH_NORMAL];
  assign out_color         = show[CH_COLOR];
  assign out_uv_a          = show[CH_UV_FIRST];
  assign out_uv_b          = show[CH_UV_FIRST+1];
  assign out_uv_c          = show[CH_UV_FIRST+2];
  assign out_uv_d          = show[CH_UV_FIRST+3];
  assign out_triangle_done = (slot_r == LAST_CORNER);

endmodule

FILE: src/fsa_checker.sv
// Port-level checks of the primitive assembler and their binding.
module fsa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fsa_pkg::FIELD_BITS-1:0]    out_position,
  input logic                              out_triangle_done
);

  import fsa_pkg::*;

  logic [1:0] corner_cnt_r;

  // Counts corners delivered within the current triangle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_cnt_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      corner_cnt_r <= out_triangle_done ? 2'd0 : corner_cnt_r + 2'd1;
    end
  end

  // Every third corner, and only it, closes a triangle.
  a_done_every_third: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_triangle_done == (corner_cnt_r == LAST_CORNER)))
    else $error("triangle_done out of step with the corner count");

  // An empty result side never holds off a vertex.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no corner pending");

  // Nothing is pending right after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("corner valid right after reset");

  // A stalled corner holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("stalled corner changed");

endmodule

bind fan_and_strip_primitive_assembler fsa_checker u_fsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_position      (out_position),
  .out_triangle_done (out_triangle_done)
);

FILE: bench/corner_stream_check.sv
// Predicts the corner stream of the primitive assembler and checks every result beat.
module corner_stream_check #(
  parameter int MAX_UV_SETS = 4,
  parameter int INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  in_starts_primitive,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_position_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_normal_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_color_index,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_a,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_b,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_c,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        in_uv_index_d,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_position,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_normal,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_color,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_a,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_b,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_c,
  input  logic [fsa_pkg::FIELD_BITS-1:0]        out_uv_d,
  input  logic                                  out_triangle_done,
  input  logic                                  cfg_write_en,
  input  logic [fsa_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fsa_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output int                                    mismatches,
  output int                                    pending_corners
);
  timeunit 1ns;
  timeprecision 1ps;

  import fsa_pkg::*;

  localparam field_t INDEX_MASK = field_t'((64'd1 << INDEX_BITS) - 64'd1);

  typedef struct packed {
    corner_t idx;
    logic    closes;
  } corner_beat_t;

  cfg_t         regs;
  logic [1:0]   vertices_held;
  logic         odd_strip_triangle;
  corner_t      anchor_idx;
  corner_t      prev_idx;
  corner_beat_t expected_corners[$];
  int           beats_checked;

  task automatic report_mismatch(string msg);
    $display("[%0t] corner check: %s", $realtime, msg);
    mismatches++;
  endtask

  // Channel enables are taken from the registers in force when the corner is formed.
  function automatic corner_beat_t emitted_corner(corner_t v, logic closes);
    corner_beat_t beat;
    int           uv_limit;
    uv_limit = (int'(regs.uv_sets_used) > MAX_UV_SETS) ? MAX_UV_SETS : int'(regs.uv_sets_used);
    beat.idx = '0;
    beat.idx[CH_POSITION] = v[CH_POSITION];
    if (regs.normals_enabled) beat.idx[CH_NORMAL] = v[CH_NORMAL];
    if (regs.colors_enabled) beat.idx[CH_COLOR] = v[CH_COLOR];
    for (int u = 0; u < NUM_UV_PORTS; u++) begin
      if (u < uv_limit) beat.idx[CH_UV_FIRST+u] = v[CH_UV_FIRST+u];
    end
    beat.closes = closes;
    return beat;
  endfunction

  task automatic assemble_vertex(logic opens, corner_t cur);
    if (opens) begin
      vertices_held = 2'd0;
      odd_strip_triangle = 1'b0;
    end
    case (vertices_held)
      2'd0: begin
        anchor_idx = cur;
        vertices_held = 2'd1;
      end
      2'd1: begin
        prev_idx = cur;
        vertices_held = 2'd2;
      end
      default: begin
        expected_corners.push_back(emitted_corner(anchor_idx, 1'b0));
        if (regs.assembly_mode == MODE_FAN) begin
          expected_corners.push_back(emitted_corner(prev_idx, 1'b0));
          expected_corners.push_back(emitted_corner(cur, 1'b1));
          prev_idx = cur;
        end else begin
          // Odd strip triangles swap their last two corners to keep the winding.
          if (odd_strip_triangle) begin
            expected_corners.push_back(emitted_corner(cur, 1'b0));
            expected_corners.push_back(emitted_corner(prev_idx, 1'b1));
          end else begin
            expected_corners.push_back(emitted_corner(prev_idx, 1'b0));
            expected_corners.push_back(emitted_corner(cur, 1'b1));
          end
          anchor_idx = prev_idx;
          prev_idx = cur;
          odd_strip_triangle = ~odd_strip_triangle;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : sample
    corner_t      got;
    corner_t      arriving;
    corner_beat_t want;
    if (!rst_n) begin
      regs = '0;
      vertices_held = 2'd0;
      odd_strip_triangle = 1'b0;
      expected_corners.delete();
      beats_checked = 0;
      mismatches = 0;
      pending_corners = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_ASSEMBLY_MODE:   regs.assembly_mode = cfg_data[0];
          CFG_NORMALS_ENABLED: regs.normals_enabled = cfg_data[0];
          CFG_COLORS_ENABLED:  regs.colors_enabled = cfg_data[0];
          CFG_UV_SETS_USED:    regs.uv_sets_used = cfg_data;
          default: ;
        endcase
      end
      // Results first: a vertex taken on this edge cannot already have a corner out.
      if (out_valid && out_ready) begin
        got[CH_POSITION] = out_position;
        got[CH_NORMAL] = out_normal;
        got[CH_COLOR] = out_color;
        got[CH_UV_FIRST] = out_uv_a;
        got[CH_UV_FIRST+1] = out_uv_b;
        got[CH_UV_FIRST+2] = out_uv_c;
        got[CH_UV_FIRST+3] = out_uv_d;
        if (expected_corners.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with no corner expected", beats_checked));
        end else begin
          want = expected_corners.pop_front();
          // Channel order: position, normal, color, then UV sets 0 to 3.
          for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (got[ch] !== want.idx[ch])
              report_mismatch($sformatf("beat %0d channel %0d: expected %h, got %h",
                                        beats_checked, ch, want.idx[ch], got[ch]));
          end
          if (out_triangle_done !== want.closes)
            report_mismatch($sformatf("beat %0d triangle_done: expected %b, got %b",
                                      beats_checked, want.closes, out_triangle_done));
        end
        beats_checked++;
      end
      if (in_valid && in_ready) begin
        arriving[CH_POSITION] = in_position_index;
        arriving[CH_NORMAL] = in_normal_index;
        arriving[CH_COLOR] = in_color_index;
        arriving[CH_UV_FIRST] = in_uv_index_a;
        arriving[CH_UV_FIRST+1] = in_uv_index_b;
        arriving[CH_UV_FIRST+2] = in_uv_index_c;
        arriving[CH_UV_FIRST+3] = in_uv_index_d;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) arriving[ch] = arriving[ch] & INDEX_MASK;
        assemble_vertex(in_starts_primitive, arriving);
      end
      pending_corners = expected_corners.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the primitive assembler bench: clock, reset, vertex and stall stimulus, and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsa_pkg::*;

  // Cycles allowed for the block to finish a vertex that closes no triangle,
  // and the quiet tail after the last expected corner.
  localparam int DRAIN_CYCLES = 8;
  // Length of the one long receiver stall that backs the block up.
  localparam int LONG_HOLD = 48;
  // Cycles with no beat on any port before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 10;

  typedef struct packed {
    logic    opens;
    corner_t idx;
  } vertex_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_starts_primitive;
  field_t in_position_index;
  field_t in_normal_index;
  field_t in_color_index;
  field_t in_uv_index_a;
  field_t in_uv_index_b;
  field_t in_uv_index_c;
  field_t in_uv_index_d;
  logic   out_valid;
  logic   out_ready;
  field_t out_position;
  field_t out_normal;
  field_t out_color;
  field_t out_uv_a;
  field_t out_uv_b;
  field_t out_uv_c;
  field_t out_uv_d;
  logic   out_triangle_done;
  logic   cfg_write_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int     mismatches;
  int     pending_corners;

  // Largest random wait per beat on each side; a phase sets them to 0 for
  // back-to-back traffic or to 5 for gaps that land on every cycle of a triangle.
  int sender_max_gap;
  int receiver_max_gap;
  // Raised by the stimulus to ask the receiver for one long stall.
  bit long_hold_req;

  fan_and_strip_primitive_assembler dut (.*);

  corner_stream_check corner_check (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offers one vertex from a falling edge and returns at the falling edge after
  // its beat. Valid is only lowered when a gap is drawn, so a back-to-back
  // vertex keeps valid high through the step with a single assignment.
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_starts_primitive <= v.opens;
    in_position_index <= v.idx[CH_POSITION];
    in_normal_index <= v.idx[CH_NORMAL];
    in_color_index <= v.idx[CH_COLOR];
    in_uv_index_a <= v.idx[CH_UV_FIRST];
    in_uv_index_b <= v.idx[CH_UV_FIRST+1];
    in_uv_index_c <= v.idx[CH_UV_FIRST+2];
    in_uv_index_d <= v.idx[CH_UV_FIRST+3];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic vertex_t uniform_vertex(logic opens, field_t value);
    vertex_t v;
    v.opens = opens;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) v.idx[ch] = value;
    return v;
  endfunction

  // Random indices, with all-zero and all-one channels mixed in now and then.
  function automatic vertex_t random_vertex(logic opens);
    vertex_t v;
    v.opens = opens;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      case ($urandom_range(0, 7))
        0:       v.idx[ch] = '0;
        1:       v.idx[ch] = '1;
        default: v.idx[ch] = field_t'($urandom);
      endcase
    end
    return v;
  endfunction

  // Stops offering vertices and waits until every predicted corner has come
  // back, then gives the block time to absorb a vertex that made no triangle.
  // Register writes are only safe after this.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_corners != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Writes all four registers on consecutive cycles. The one-bit registers get
  // random upper data bits, which the block has to ignore.
  task automatic program_registers(logic mode, logic normals, logic colors,
                                   logic [CFG_DATA_BITS-1:0] uv_sets);
    write_register(CFG_ASSEMBLY_MODE, {2'($urandom), mode});
    write_register(CFG_NORMALS_ENABLED, {2'($urandom), normals});
    write_register(CFG_COLORS_ENABLED, {2'($urandom), colors});
    write_register(CFG_UV_SETS_USED, uv_sets);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly well-formed primitives of three to eight vertices with random
  // contents. The rest is noise: one- and two-vertex primitives, a primitive
  // that continues the previous one without a start flag, and stray start
  // flags that break a primitive in the middle.
  task automatic run_phase(int items);
    int sent;
    int length;
    logic opens_first;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) == 0) length = $urandom_range(1, 2);
      else length = $urandom_range(3, 8);
      opens_first = ($urandom_range(0, 7) != 0);
      for (int k = 0; k < length; k++)
        send_vertex(random_vertex((k == 0) ? opens_first : ($urandom_range(0, 15) == 0)));
      sent += length;
    end
  endtask

  // Receiver: draws a wait before every corner beat, or serves one long stall
  // when asked, counting the stall cycles here so the sender keeps pushing
  // vertices until the block fills up and drops in_ready.
  initial begin : receiver
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) hold = LONG_HOLD;
      else hold = $urandom_range(0, receiver_max_gap);
      long_hold_req = 1'b0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Any beat on any port counts as progress; a long quiet stretch means the
  // block or the bench is stuck.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_starts_primitive = 1'b0;
    in_position_index = '0;
    in_normal_index = '0;
    in_color_index = '0;
    in_uv_index_a = '0;
    in_uv_index_b = '0;
    in_uv_index_c = '0;
    in_uv_index_d = '0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender_max_gap = 0;
    receiver_max_gap = 0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Fan mode with every channel passed through.
    program_registers(MODE_FAN, 1'b1, 1'b1, 3'd4);
    // The very first vertex carries no start flag and still opens a polygon;
    // all-zero, all-one and alternating indices give two fan triangles.
    send_vertex(uniform_vertex(1'b0, '0));
    send_vertex(uniform_vertex(1'b0, '1));
    send_vertex(uniform_vertex(1'b0, 24'hAAAAAA));
    send_vertex(uniform_vertex(1'b0, 24'h555555));
    // A two-vertex primitive and a one-vertex primitive produce nothing.
    send_vertex(random_vertex(1'b1));
    send_vertex(random_vertex(1'b0));
    send_vertex(random_vertex(1'b1));

    // Strip mode with every optional channel off: four triangles, the odd
    // ones with their last two corners swapped.
    settle();
    program_registers(MODE_STRIP, 1'b0, 1'b0, 3'd0);
    send_vertex(random_vertex(1'b1));
    repeat (5) send_vertex(random_vertex(1'b0));

    // Mode switched inside the open strip: assembly goes on from the stored
    // vertices. A UV count above the number of UV ports saturates.
    settle();
    program_registers(MODE_FAN, 1'b1, 1'b0, 3'd7);
    repeat (2) send_vertex(random_vertex(1'b0));
    settle();
    program_registers(MODE_STRIP, 1'b0, 1'b1, 3'd5);
    sender_max_gap = 5;
    receiver_max_gap = 5;
    repeat (2) send_vertex(random_vertex(1'b0));

    // Random part, one register setting per phase. The first two phases use
    // the extreme settings; the others draw raw register values.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0:       program_registers(MODE_FAN, 1'b0, 1'b0, 3'd0);
        1:       program_registers(MODE_STRIP, 1'b1, 1'b1, 3'd7);
        default: program_registers(1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom));
      endcase
      sender_max_gap = (p % 3 == 0) ? 0 : 5;
      receiver_max_gap = (p % 4 == 1) ? 0 : 5;
      if (p == 4) begin
        // Back-to-back vertices into a receiver that stops for a long while.
        sender_max_gap = 0;
        long_hold_req = 1'b1;
      end
      if (p == 6) begin
        // The sender pauses in the middle of the phase until the block drains.
        run_phase(19);
        settle();
        run_phase(19);
      end else begin
        run_phase(38);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
